// ===== design/glob_wildcard_matcher_macros.svh =====
// assertion macros for the glob wildcard matcher
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH

// same-cycle implication, checked out of reset
`define GWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gwm_pkg.sv =====
// shared types and constants of the glob wildcard matcher
package gwm_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    localparam logic [7:0] CH_ANY  = 8'h3F;
    localparam logic [7:0] CH_STAR = 8'h2A;

    // control broadcast to every cell
    typedef struct packed {
        logic       rearm;
        logic       advance;
        logic [7:0] ch;
    } cell_ctl_t;

endpackage

// ===== design/gwm_in_if.sv =====
// input channel: command and character byte
interface gwm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_value;

    modport source (output valid, output command, output char_value, input ready);
    modport sink (input valid, input command, input char_value, output ready);
endinterface

// ===== design/gwm_out_if.sv =====
// output channel: match verdict and overflow flag
interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== design/glob_wildcard_matcher.sv =====
// top level of the glob wildcard matcher: cell chain, pattern length and verdict
//
//  channel | dir | fields                       | items
//  --------+-----+------------------------------+-------------------------------
//  in      | in  | command, char_value          | clear, append, text, end
//  out     | out | matched, pattern_overflow    | one per end-of-text command
//
// an item can be accepted in every cycle unless the output register is stalled
// the closure over star cells ripples through the cell chain in the same cycle
// a verdict sits in the output register; in.ready drops only while it is stalled
// reset leaves an empty pattern with only the start position active
`include "glob_wildcard_matcher_macros.svh"

module glob_wildcard_matcher #(
    parameter int MAX_PATTERN = 32
) (
    input logic        clk,
    input logic        rst_n,
    gwm_in_if.sink     in,
    gwm_out_if.source  out
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    gwm_pkg::cell_ctl_t ctl;
    gwm_pkg::cmd_t      cmd;

    logic                 accept;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 final_reg;
    logic                 final_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 matched_reg;
    logic                 matched_next;
    logic                 out_ovf_reg;
    logic                 out_ovf_next;
    logic                 full;

    // closed active set, one bit per position including the final one
    logic [MAX_PATTERN:0]   closed_vec;
    logic [MAX_PATTERN:0]   carry_vec;
    logic [MAX_PATTERN:0]   adv_vec;

    assign cmd    = gwm_pkg::cmd_t'(in.command);
    assign accept = in.valid & in.ready;
    assign full   = (len_reg == LEN_W'(MAX_PATTERN));

    // output register frees up in the cycle its item is taken
    assign in.ready = ~out_valid_reg | out.ready;

    always_comb
    begin
        ctl.ch      = in.char_value;
        ctl.rearm   = 1'b0;
        ctl.advance = 1'b0;
        if (accept)
        begin
            unique case (cmd)
                gwm_pkg::CMD_TEXT: ctl.advance = 1'b1;
                default:           ctl.rearm   = 1'b1;
            endcase
        end
    end

    assign carry_vec[0] = 1'b0;
    assign adv_vec[0]   = 1'b0;

    // chain of cells, cell i holds pattern byte i and position i
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        logic wr_en;
        logic in_pattern;

        assign wr_en      = accept && (cmd == gwm_pkg::CMD_APPEND)
                            && (len_reg == LEN_W'(i));
        assign in_pattern = (LEN_W'(i) < len_reg);

        gwm_cell #(
            .START_CELL (i == 0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .wr_en      (wr_en),
            .in_pattern (in_pattern),
            .carry_in   (carry_vec[i]),
            .adv_in     (adv_vec[i]),
            .closed     (closed_vec[i]),
            .carry_out  (carry_vec[i+1]),
            .adv_out    (adv_vec[i+1])
        );
    end

    // position past the last cell
    assign closed_vec[MAX_PATTERN] = final_reg | carry_vec[MAX_PATTERN];

    always_comb
    begin
        final_next = final_reg;
        if (ctl.rearm)
        begin
            final_next = 1'b0;
        end
        else if (ctl.advance)
        begin
            final_next = adv_vec[MAX_PATTERN];
        end
    end

    // pattern length and overflow
    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            case (cmd)
                gwm_pkg::CMD_CLEAR:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                gwm_pkg::CMD_APPEND:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // verdict register
    always_comb
    begin
        out_valid_next = out_valid_reg & ~out.ready;
        matched_next   = matched_reg;
        out_ovf_next   = out_ovf_reg;
        if (accept && (cmd == gwm_pkg::CMD_END))
        begin
            out_valid_next = 1'b1;
            matched_next   = closed_vec[len_reg];
            out_ovf_next   = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign out.valid            = out_valid_reg;
    assign out.matched          = matched_reg;
    assign out.pattern_overflow = out_ovf_reg;

    `GWM_ASSERT_NEXT(a_end_gives_item, accept && (cmd == gwm_pkg::CMD_END), out_valid_reg,
        "end of text gave no verdict")
    `GWM_ASSERT_NOW(a_ovf_only_full, ovf_reg, full, "overflow set with room in the store")
    `GWM_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_W'(MAX_PATTERN),
        "pattern length past the store")
    `GWM_ASSERT_NEXT(a_rearm_start, ctl.rearm, closed_vec[0] && !final_reg,
        "rearm did not restore the start position")

endmodule

// ===== design/gwm_cell.sv =====
// one pattern cell: stored byte plus the active bit of its position
module gwm_cell #(
    parameter bit START_CELL = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gwm_pkg::cell_ctl_t ctl,
    input  logic              wr_en,
    input  logic              in_pattern,
    input  logic              carry_in,
    input  logic              adv_in,
    output logic              closed,
    output logic              carry_out,
    output logic              adv_out
);

    logic [7:0] char_reg;
    logic       base_reg;
    logic       base_next;
    logic       is_star;
    logic       hit;

    assign is_star   = (char_reg == gwm_pkg::CH_STAR);
    assign hit       = (char_reg == gwm_pkg::CH_ANY) || (char_reg == ctl.ch);
    assign closed    = base_reg | carry_in;
    assign carry_out = closed & in_pattern & is_star;
    assign adv_out   = closed & in_pattern & ~is_star & hit;

    always_comb
    begin
        base_next = base_reg;
        if (ctl.rearm)
        begin
            base_next = START_CELL;
        end
        else if (ctl.advance)
        begin
            // a star keeps its own position, a hit on the left moves in
            base_next = carry_out | adv_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= START_CELL;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            char_reg <= ctl.ch;
        end
    end

endmodule

// ===== dv/glob_verdict_checker.sv =====
// checker for the glob matcher: tracks the pattern and active set, compares each verdict
module glob_verdict_checker #(
    parameter int MAX_PATTERN = 32
) (
    input  logic clk,
    input  logic rst_n,
    gwm_in_if    cmd_ch,
    gwm_out_if   verdict_ch,
    output int   mismatch_count,
    output int   verdicts_owed
);

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    verdict_t owed_q[$];

    logic [7:0]           pat_cells [MAX_PATTERN];
    int unsigned          pat_len;
    logic [MAX_PATTERN:0] live_pos;
    logic                 overflow_seen;

    // every live star cell also makes the next position live
    function automatic logic [MAX_PATTERN:0] close_stars(input logic [MAX_PATTERN:0] s);
        logic [MAX_PATTERN:0] r;
        int i;
        r = s;
        for (i = 0; i < pat_len; i++)
        begin
            if (r[i] && pat_cells[i] == gwm_pkg::CH_STAR)
                r[i + 1] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [MAX_PATTERN:0] start_set();
        return close_stars((MAX_PATTERN + 1)'(1));
    endfunction

    function automatic logic [MAX_PATTERN:0] step_text(input logic [7:0] c);
        logic [MAX_PATTERN:0] nxt;
        int i;
        nxt = '0;
        for (i = 0; i < pat_len; i++)
        begin
            if (live_pos[i])
            begin
                if (pat_cells[i] == gwm_pkg::CH_STAR)
                    nxt[i] = 1'b1;
                else if (pat_cells[i] == gwm_pkg::CH_ANY || pat_cells[i] == c)
                    nxt[i + 1] = 1'b1;
            end
        end
        return close_stars(nxt);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t owed_v;
        int errs;
        if (!rst_n)
        begin
            pat_len        = 0;
            overflow_seen  = 1'b0;
            live_pos       = (MAX_PATTERN + 1)'(1);
            owed_q.delete();
            mismatch_count <= 0;
            verdicts_owed  <= 0;
        end
        else
        begin
            errs = 0;
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $display("%0t unexpected verdict: expected none, got matched %0b overflow %0b",
                             $time, verdict_ch.matched, verdict_ch.pattern_overflow);
                    errs++;
                end
                else
                begin
                    owed_v = owed_q.pop_front();
                    if (verdict_ch.matched !== owed_v.matched)
                    begin
                        $display("%0t matched: expected %0b, got %0b",
                                 $time, owed_v.matched, verdict_ch.matched);
                        errs++;
                    end
                    if (verdict_ch.pattern_overflow !== owed_v.overflow)
                    begin
                        $display("%0t pattern_overflow: expected %0b, got %0b",
                                 $time, owed_v.overflow, verdict_ch.pattern_overflow);
                        errs++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                case (gwm_pkg::cmd_t'(cmd_ch.command))
                    gwm_pkg::CMD_CLEAR:
                    begin
                        pat_len       = 0;
                        overflow_seen = 1'b0;
                        live_pos      = start_set();
                    end
                    gwm_pkg::CMD_APPEND:
                    begin
                        if (pat_len < MAX_PATTERN)
                        begin
                            pat_cells[pat_len] = cmd_ch.char_value;
                            pat_len++;
                        end
                        else
                            overflow_seen = 1'b1;
                        live_pos = start_set();
                    end
                    gwm_pkg::CMD_TEXT:
                        live_pos = step_text(cmd_ch.char_value);
                    default:
                    begin
                        owed_v.matched  = live_pos[pat_len];
                        owed_v.overflow = overflow_seen;
                        owed_q.insert(owed_q.size(), owed_v);
                        live_pos = start_set();
                    end
                endcase
            end
            mismatch_count <= mismatch_count + errs;
            verdicts_owed  <= owed_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// top of the glob matcher testbench: clock, reset, stimulus, stalls and verdict
module tb_top;

    localparam int PAT_CELLS    = 32;
    localparam int DIRECTED_CNT = 25;
    localparam int RANDOM_CNT   = 1525;
    // no handshake for this many cycles means the block is stuck
    localparam int QUIET_LIMIT  = 4000;

    logic clk;
    logic rst_n;

    gwm_in_if  in_ch();
    gwm_out_if out_ch();

    int mismatch_count;
    int verdicts_owed;
    int items_sent;
    int sender_idle_pct;
    int receiver_idle_pct;
    int quiet_cycles;

    // the pattern cells the block actually holds, used to build matching texts
    logic [7:0] pat_q[$];

    glob_wildcard_matcher #(
        .MAX_PATTERN(PAT_CELLS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    glob_verdict_checker #(
        .MAX_PATTERN(PAT_CELLS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_ch         (in_ch),
        .verdict_ch     (out_ch),
        .mismatch_count (mismatch_count),
        .verdicts_owed  (verdicts_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver side: stall at the rate of the current phase
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // watchdog: any handshake on either channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one item, with random idle cycles ahead of it, and hold it until taken
    task automatic send(input gwm_pkg::cmd_t cmd, input logic [7:0] ch);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.char_value <= ch;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // pattern bytes lean on wildcards and a tiny alphabet so texts can match
    function automatic logic [7:0] pick_pattern_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return gwm_pkg::CH_STAR;
        else if (r < 5)
            return gwm_pkg::CH_ANY;
        else if (r < 8)
            return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_char();
        if ($urandom_range(0, 9) < 7)
            return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    // one well-formed job: clear, load a pattern, then a few texts each closed by an end
    task automatic run_string();
        logic [7:0] txt_q[$];
        logic [7:0] pc;
        int len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            len = $urandom_range(PAT_CELLS + 1, PAT_CELLS + 4);  // overflows the store
        else if (r < 15)
            len = $urandom_range(9, PAT_CELLS);
        else
            len = $urandom_range(0, 8);
        pat_q.delete();
        send(gwm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
        repeat (len)
        begin
            pc = pick_pattern_char();
            if (pat_q.size() < PAT_CELLS)
                pat_q.insert(pat_q.size(), pc);
            send(gwm_pkg::CMD_APPEND, pc);
        end
        repeat ($urandom_range(1, 3))
        begin
            txt_q.delete();
            if ($urandom_range(0, 2) != 0)
            begin
                // text that follows the pattern, so most of these should match
                foreach (pat_q[i])
                begin
                    if (pat_q[i] == gwm_pkg::CH_STAR)
                        repeat ($urandom_range(0, 3))
                            txt_q.insert(txt_q.size(), pick_text_char());
                    else if (pat_q[i] == gwm_pkg::CH_ANY)
                        txt_q.insert(txt_q.size(), 8'($urandom_range(0, 255)));
                    else
                        txt_q.insert(txt_q.size(), pat_q[i]);
                end
                // now and then spoil one byte
                if (txt_q.size() > 0 && $urandom_range(0, 4) == 0)
                    txt_q[$urandom_range(0, txt_q.size() - 1)] = pick_text_char();
            end
            else
            begin
                repeat ($urandom_range(0, 8)) txt_q.insert(txt_q.size(), pick_text_char());
            end
            foreach (txt_q[i])
            begin
                // rare append in the middle of a text restarts the active set
                if ($urandom_range(0, 39) == 0)
                begin
                    pc = pick_pattern_char();
                    if (pat_q.size() < PAT_CELLS)
                        pat_q.insert(pat_q.size(), pc);
                    send(gwm_pkg::CMD_APPEND, pc);
                end
                send(gwm_pkg::CMD_TEXT, txt_q[i]);
            end
            send(gwm_pkg::CMD_END, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        in_ch.valid      <= 1'b0;
        in_ch.command    <= gwm_pkg::CMD_CLEAR;
        in_ch.char_value <= 8'h00;
        rst_n            <= 1'b0;
        items_sent        = 0;
        sender_idle_pct   = 19;
        receiver_idle_pct = 81;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty pattern against empty text, then against one byte
        send(gwm_pkg::CMD_END, 8'h00);
        send(gwm_pkg::CMD_TEXT, 8'h61);
        send(gwm_pkg::CMD_END, 8'hFF);
        // stars only: empty text matches, and so does any text
        send(gwm_pkg::CMD_APPEND, gwm_pkg::CH_STAR);
        send(gwm_pkg::CMD_APPEND, gwm_pkg::CH_STAR);
        send(gwm_pkg::CMD_END, 8'h00);
        send(gwm_pkg::CMD_TEXT, 8'h71);
        send(gwm_pkg::CMD_END, 8'h00);
        // byte zero and 0xff as ordinary pattern bytes around '?' and '*'
        send(gwm_pkg::CMD_CLEAR, 8'hFF);
        send(gwm_pkg::CMD_APPEND, 8'h00);
        send(gwm_pkg::CMD_APPEND, gwm_pkg::CH_ANY);
        send(gwm_pkg::CMD_APPEND, gwm_pkg::CH_STAR);
        send(gwm_pkg::CMD_APPEND, 8'hFF);
        send(gwm_pkg::CMD_TEXT, 8'h00);
        send(gwm_pkg::CMD_TEXT, 8'h55);
        send(gwm_pkg::CMD_TEXT, 8'hAA);
        send(gwm_pkg::CMD_TEXT, 8'hFF);
        send(gwm_pkg::CMD_END, 8'h00);
        // first byte kills every position; the set stays empty
        send(gwm_pkg::CMD_TEXT, 8'h01);
        send(gwm_pkg::CMD_TEXT, 8'h00);
        send(gwm_pkg::CMD_TEXT, 8'hFF);
        send(gwm_pkg::CMD_END, 8'h00);
        // append in the middle of a text forgets the bytes already given
        send(gwm_pkg::CMD_TEXT, 8'h00);
        send(gwm_pkg::CMD_APPEND, gwm_pkg::CH_ANY);
        send(gwm_pkg::CMD_END, 8'h00);

        // random jobs, with occasional bursts of arbitrary commands
        while (items_sent < DIRECTED_CNT + RANDOM_CNT)
        begin
            if (items_sent < DIRECTED_CNT + RANDOM_CNT / 3)
            begin
                sender_idle_pct   = 19;
                receiver_idle_pct = 81;
            end
            else if (items_sent < DIRECTED_CNT + 2 * RANDOM_CNT / 3)
            begin
                sender_idle_pct   = 81;
                receiver_idle_pct = 19;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6))
                    send(gwm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else
                run_string();
        end
        in_ch.valid <= 1'b0;
        receiver_idle_pct = 0;

        // drain the outstanding verdicts; the watchdog bounds this wait
        do
            @(posedge clk);
        while (verdicts_owed != 0);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && verdicts_owed == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== glob_wildcard_matcher.f =====
+incdir+design
design/gwm_pkg.sv
design/gwm_in_if.sv
design/gwm_out_if.sv
design/gwm_cell.sv
design/glob_wildcard_matcher.sv
dv/glob_verdict_checker.sv
dv/tb_top.sv
